>>> hdl/stack_with_add_and_listing_defines.svh
// Assertion macros shared by the stack block.
`ifndef STACK_WITH_ADD_AND_LISTING_DEFINES_SVH
`define STACK_WITH_ADD_AND_LISTING_DEFINES_SVH

// Checked on every clock edge outside reset.
`define SWAL_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define SWAL_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> hdl/swal_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package swal_pkg;

  // Stack capacity and the widths that follow from it.
  localparam int DEPTH  = 64;
  localparam int DATA_W = 32;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int REQ_W  = 3;
  localparam int STAT_W = 2;

  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

  // Request codes.
  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH = 3'd0,
    REQ_POP  = 3'd1,
    REQ_PEEK = 3'd2,
    REQ_ADD  = 3'd3,
    REQ_LIST = 3'd4
  } req_t;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    STAT_OK         = 2'd0,
    STAT_SHORT      = 2'd1,
    STAT_FULL       = 2'd2,
    STAT_EMPTY_LIST = 2'd3
  } status_t;

  // One result word as it travels from the controller to the output stage.
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    status_t                  status;
    logic                     last;
  } result_t;

endpackage

`default_nettype wire

>>> hdl/stack_with_add_and_listing.sv
// Push, peek, error and single-entry pop results are emitted from the execute state;
// other pops and adds read the entry below the top there and are emitted from the fix-up
// state; a list reads from the execute state, then gives one entry per cycle from the
// listing state while it is taken. A new word is accepted only in the idle state, once
// the previous request has emitted all its words.
// Reset clears the entry count, the sequencer state and the output valid; memory is kept.
`timescale 1ns / 1ps
`default_nettype none

module stack_with_add_and_listing (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [swal_pkg::REQ_W-1:0]         req_type,
  input  wire logic signed [swal_pkg::DATA_W-1:0] push_value,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic signed [swal_pkg::DATA_W-1:0]      result_value,
  output logic [swal_pkg::STAT_W-1:0]             status,
  output logic                                    last_item
);

  import swal_pkg::*;

  logic    obuf_free;
  logic    emit;
  result_t emit_word;
  result_t out_word;

  // Request sequencer with the entry memory.
  swal_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .push_value (push_value),
    .obuf_free  (obuf_free),
    .emit       (emit),
    .emit_word  (emit_word)
  );

  // Output register between the sequencer and the result channel.
  swal_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .load      (emit),
    .load_word (emit_word),
    .free      (obuf_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .word      (out_word)
  );

  assign result_value = out_word.value;
  assign status       = out_word.status;
  assign last_item    = out_word.last;

endmodule

`default_nettype wire

>>> hdl/swal_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module swal_ram #(
  parameter int DATA_W = 32,
  parameter int ADDR_W = 6
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  // Single write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> hdl/swal_obuf.sv
`timescale 1ns / 1ps
`default_nettype none

module swal_obuf (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire swal_pkg::result_t load_word,
  output logic                   free,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output swal_pkg::result_t      word
);

  import swal_pkg::*;

  // The slot can take a new word when it is empty or drains this cycle.
  assign free = !out_valid || out_ready;

  // Output register holding one result word.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (load) begin
      word <= load_word;
    end
  end

endmodule

`default_nettype wire

>>> hdl/swal_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
`include "stack_with_add_and_listing_defines.svh"

module swal_ctrl (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [swal_pkg::REQ_W-1:0]     req_type,
  input  wire logic signed [swal_pkg::DATA_W-1:0] push_value,
  input  wire logic                           obuf_free,
  output logic                                emit,
  output swal_pkg::result_t                   emit_word
);

  import swal_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_FIX,
    S_LIST
  } state_t;

  state_t                   state, state_next;
  logic [REQ_W-1:0]         req;
  logic signed [DATA_W-1:0] val;
  logic [CNT_W-1:0]         count, count_next;
  logic signed [DATA_W-1:0] top_val, top_next;
  logic [ADDR_W-1:0]        list_idx, idx_next;

  logic                     ram_we, ram_re;
  logic [ADDR_W-1:0]        ram_waddr, ram_raddr;
  logic [DATA_W-1:0]        ram_wdata, ram_rdata;

  logic [CNT_W-1:0]         count_m1, count_m2;
  logic                     is_empty, is_short, is_full;
  logic signed [DATA_W-1:0] sum;

  // Entry memory; the top entry is also cached in top_val.
  swal_ram #(
    .DATA_W (DATA_W),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign count_m1 = count - CNT_W'(1);
  assign count_m2 = count - CNT_W'(2);
  assign is_empty = (count == '0);
  assign is_short = (count < CNT_W'(2));
  assign is_full  = (count == FULL_COUNT);
  assign sum      = top_val + $signed(ram_rdata);

  assign in_ready = (state == S_IDLE);

  // Request sequencing. Writes happen in the execute and fix-up cycles and reads
  // in the execute and listing cycles of the same item, so a read never meets a
  // write to the same entry in one cycle.
  always_comb begin
    state_next = state;
    count_next = count;
    top_next   = top_val;
    idx_next   = list_idx;
    ram_we     = 1'b0;
    ram_waddr  = count[ADDR_W-1:0];
    ram_wdata  = val;
    ram_re     = 1'b0;
    ram_raddr  = count_m2[ADDR_W-1:0];
    emit       = 1'b0;
    emit_word  = '{value: '0, status: STAT_OK, last: 1'b1};

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        if (obuf_free) begin
          state_next = S_IDLE;
          case (req)
            REQ_PUSH: begin
              emit = 1'b1;
              if (is_full) begin
                emit_word.status = STAT_FULL;
              end else begin
                ram_we     = 1'b1;
                top_next   = val;
                count_next = count + CNT_W'(1);
              end
            end
            REQ_POP: begin
              if (is_empty) begin
                emit             = 1'b1;
                emit_word.status = STAT_SHORT;
              end else if (is_short) begin
                emit       = 1'b1;
                count_next = '0;
              end else begin
                ram_re     = 1'b1;
                state_next = S_FIX;
              end
            end
            REQ_PEEK: begin
              emit = 1'b1;
              if (is_empty) begin
                emit_word.status = STAT_SHORT;
              end else begin
                emit_word.value = top_val;
              end
            end
            REQ_ADD: begin
              if (is_short) begin
                emit             = 1'b1;
                emit_word.status = STAT_SHORT;
              end else begin
                ram_re     = 1'b1;
                state_next = S_FIX;
              end
            end
            REQ_LIST: begin
              if (is_empty) begin
                emit             = 1'b1;
                emit_word.status = STAT_EMPTY_LIST;
              end else begin
                ram_re     = 1'b1;
                ram_raddr  = count_m1[ADDR_W-1:0];
                idx_next   = count_m1[ADDR_W-1:0];
                state_next = S_LIST;
              end
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end

      // Second half of pop and add: the entry below the top has been read.
      S_FIX: begin
        if (obuf_free) begin
          emit       = 1'b1;
          count_next = count_m1;
          state_next = S_IDLE;
          if (req == REQ_ADD) begin
            ram_we          = 1'b1;
            ram_waddr       = count_m2[ADDR_W-1:0];
            ram_wdata       = sum;
            top_next        = sum;
            emit_word.value = sum;
          end else begin
            top_next = $signed(ram_rdata);
          end
        end
      end

      // Walk from the top down, one entry per free output slot.
      S_LIST: begin
        if (obuf_free) begin
          emit            = 1'b1;
          emit_word.value = $signed(ram_rdata);
          emit_word.last  = (list_idx == '0);
          if (list_idx == '0) begin
            state_next = S_IDLE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = list_idx - ADDR_W'(1);
            idx_next  = list_idx - ADDR_W'(1);
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State, stack pointer, cached top and the latched request.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      list_idx <= '0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      list_idx <= idx_next;
    end
    top_val <= top_next;
    if (in_valid && in_ready) begin
      req <= req_type;
      val <= push_value;
    end
  end

  `SWAL_ASSERT_ALWAYS(a_reset_clears, rst |=> (state == S_IDLE && count == '0), "reset did not clear the stack")
  `SWAL_ASSERT(a_count_bound, count <= FULL_COUNT, "entry count above capacity")
  `SWAL_ASSERT(a_no_collide, !(ram_we && ram_re && ram_waddr == ram_raddr), "read and write hit the same entry")
  `SWAL_ASSERT(a_accept_exec, (in_valid && in_ready) |=> state == S_EXEC, "accepted word not executed")
  `SWAL_ASSERT(a_list_end, (state == S_LIST && emit && emit_word.last) |=> state == S_IDLE, "listing ran past the bottom entry")

endmodule

`default_nettype wire

>>> bench/tb_stack_with_add_and_listing.sv
`timescale 1ns / 1ps

module tb_stack_with_add_and_listing;
  import swal_pkg::*;

  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 12;
  localparam int MAX_GAP       = 9;
  localparam int LONG_HOLD     = 160;
  localparam int SETTLE_CYCLES = 4;
  localparam int QUIET_LIMIT   = 3000;

  // Request codes the block must ignore.
  localparam logic [REQ_W-1:0] FIRST_SPARE = 3'd5;
  localparam logic [REQ_W-1:0] LAST_SPARE  = 3'd7;

  localparam logic signed [DATA_W-1:0] VAL_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] VAL_MIN   = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_ALT_A = 32'shAAAA_AAAA;
  localparam logic signed [DATA_W-1:0] VAL_ALT_B = 32'sh5555_5555;

  typedef struct {
    logic [REQ_W-1:0]         op;
    logic signed [DATA_W-1:0] value;
  } stack_req_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [REQ_W-1:0]         req_type = '0;
  logic signed [DATA_W-1:0] push_value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [DATA_W-1:0] result_value;
  logic [STAT_W-1:0]        status;
  logic                     last_item;

  // Requests waiting to be offered, and result words still owed by the block.
  stack_req_t req_backlog[$];
  result_t    expected_words[$];

  // Shadow copy of the stack contents.
  logic signed [DATA_W-1:0] shadow_stack [DEPTH];
  int                       shadow_depth = 0;

  // Handshake flags seen at the last rising edge.
  logic in_taken  = 1'b0;
  logic out_taken = 1'b0;

  bit sender_idle_en   = 1'b1;
  bit receiver_idle_en = 1'b1;
  bit long_hold_req    = 1'b0;
  bit long_hold_taken  = 1'b0;

  int gap_left   = 0;
  int stall_left = 0;
  int stall_draw = 0;
  int hold_left  = 0;

  int quiet_cycles = 0;
  int err_count    = 0;
  int n_requests   = 0;
  int n_results    = 0;
  int n_full       = 0;
  int n_short      = 0;
  int n_lists      = 0;
  int longest_list = 0;

  stack_req_t next_req;
  result_t    exp_w;

  stack_with_add_and_listing u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .push_value   (push_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_value (result_value),
    .status       (status),
    .last_item    (last_item)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // Queue one result word that the block owes.
  task automatic owe_word(input logic signed [DATA_W-1:0] value, input status_t st,
                          input logic last);
    result_t w;
    w.value  = value;
    w.status = st;
    w.last   = last;
    expected_words.push_back(w);
  endtask

  // Apply one accepted request to the shadow stack and queue what it yields.
  task automatic stack_predict(input logic [REQ_W-1:0] op, input logic signed [DATA_W-1:0] v);
    logic signed [DATA_W-1:0] sum;
    case (op)
      REQ_PUSH: begin
        if (shadow_depth >= DEPTH) begin
          owe_word('0, STAT_FULL, 1'b1);
          n_full++;
        end else begin
          shadow_stack[shadow_depth] = v;
          shadow_depth++;
          owe_word('0, STAT_OK, 1'b1);
        end
      end
      REQ_POP: begin
        if (shadow_depth == 0) begin
          owe_word('0, STAT_SHORT, 1'b1);
          n_short++;
        end else begin
          shadow_depth--;
          owe_word('0, STAT_OK, 1'b1);
        end
      end
      REQ_PEEK: begin
        if (shadow_depth == 0) begin
          owe_word('0, STAT_SHORT, 1'b1);
          n_short++;
        end else begin
          owe_word(shadow_stack[shadow_depth-1], STAT_OK, 1'b1);
        end
      end
      REQ_ADD: begin
        if (shadow_depth < 2) begin
          owe_word('0, STAT_SHORT, 1'b1);
          n_short++;
        end else begin
          // The sum wraps at 32 bits with no error.
          sum = shadow_stack[shadow_depth-1] + shadow_stack[shadow_depth-2];
          shadow_stack[shadow_depth-2] = sum;
          shadow_depth--;
          owe_word(sum, STAT_OK, 1'b1);
        end
      end
      REQ_LIST: begin
        n_lists++;
        if (shadow_depth == 0) begin
          owe_word('0, STAT_EMPTY_LIST, 1'b1);
        end else begin
          if (shadow_depth > longest_list) longest_list = shadow_depth;
          for (int i = shadow_depth - 1; i >= 0; i--)
            owe_word(shadow_stack[i], STAT_OK, i == 0);
        end
      end
      default: begin
        // Spare codes leave the stack alone and yield nothing.
      end
    endcase
  endtask

  // Request driver: presents the next word after the drawn gap.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else if (!in_valid || in_taken) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (req_backlog.size() > 0) begin
        next_req = req_backlog.pop_front();
        in_valid   <= 1'b1;
        req_type   <= next_req.op;
        push_value <= next_req.value;
        gap_left   <= sender_idle_en ? $urandom_range(0, MAX_GAP) : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stall after each word, plus one long hold on request.
  always @(negedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
      hold_left  <= 0;
    end else if (long_hold_req && !long_hold_taken) begin
      long_hold_taken <= 1'b1;
      hold_left       <= LONG_HOLD;
      out_ready       <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (out_taken && receiver_idle_en) begin
      stall_draw = $urandom_range(0, MAX_GAP);
      stall_left <= stall_draw;
      out_ready  <= (stall_draw == 0);
    end else if (stall_left > 0) begin
      out_ready  <= (stall_left == 1);
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor: checks each result word, then predicts from each accepted request.
  always @(posedge clk) begin
    in_taken  <= !rst && in_valid && in_ready;
    out_taken <= !rst && out_valid && out_ready;
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;

      if (out_valid && out_ready) begin
        n_results++;
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word value=%0d status=%0d last=%0b",
                   $time, result_value, status, last_item);
          err_count++;
        end else begin
          exp_w = expected_words.pop_front();
          if (result_value !== exp_w.value) begin
            $display("%0t: result_value expected %0d actual %0d",
                     $time, exp_w.value, result_value);
            err_count++;
          end
          if (status !== exp_w.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_w.status, status);
            err_count++;
          end
          if (last_item !== exp_w.last) begin
            $display("%0t: last_item expected %0b actual %0b", $time, exp_w.last, last_item);
            err_count++;
          end
        end
      end

      if (in_valid && in_ready) begin
        n_requests++;
        stack_predict(req_type, push_value);
      end
    end
  end

  // Watchdog on cycles with no handshake at all.
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("Timeout: no word moved for %0d cycles", QUIET_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic send_req(input logic [REQ_W-1:0] op, input logic signed [DATA_W-1:0] v);
    stack_req_t r;
    r.op    = op;
    r.value = v;
    req_backlog.push_back(r);
  endtask

  // Hold off new requests until every owed word is back and the block has settled.
  task automatic wait_idle();
    while (req_backlog.size() != 0 || in_valid || expected_words.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [REQ_W-1:0] pick_op();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 35) return REQ_PUSH;
    if (roll < 55) return REQ_POP;
    if (roll < 67) return REQ_PEEK;
    if (roll < 85) return REQ_ADD;
    if (roll < 93) return REQ_LIST;
    return REQ_W'($urandom_range(FIRST_SPARE, LAST_SPARE));
  endfunction

  task automatic random_burst(input int count);
    for (int i = 0; i < count; i++) send_req(pick_op(), pick_value());
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty-stack errors, spare codes, extremes and wrapping adds.
    send_req(REQ_LIST, pick_value());
    send_req(REQ_POP, pick_value());
    send_req(REQ_PEEK, pick_value());
    send_req(REQ_ADD, pick_value());
    for (int c = FIRST_SPARE; c <= LAST_SPARE; c++) send_req(REQ_W'(c), pick_value());
    send_req(REQ_PUSH, VAL_MAX);
    send_req(REQ_ADD, pick_value());
    send_req(REQ_PEEK, pick_value());
    send_req(REQ_PUSH, VAL_MIN);
    send_req(REQ_ADD, pick_value());
    send_req(REQ_PUSH, VAL_MAX);
    send_req(REQ_PUSH, 32'sd1);
    send_req(REQ_ADD, pick_value());
    send_req(REQ_ADD, pick_value());
    send_req(REQ_PUSH, VAL_ALT_A);
    send_req(REQ_PUSH, VAL_ALT_B);
    send_req(REQ_PUSH, '0);
    send_req(REQ_LIST, pick_value());
    send_req(REQ_POP, pick_value());
    send_req(REQ_POP, pick_value());
    send_req(REQ_PEEK, pick_value());
    send_req(REQ_POP, pick_value());
    send_req(REQ_POP, pick_value());
    wait_idle();

    // Fill past capacity while the receiver holds off, then list the full stack.
    long_hold_req = 1'b1;
    for (int i = 0; i < DEPTH + 2; i++) send_req(REQ_PUSH, pick_value());
    send_req(REQ_LIST, pick_value());
    send_req(REQ_PEEK, pick_value());
    wait_idle();

    // Shrink the stack with pops and adds.
    for (int i = 0; i < 45; i++)
      send_req(($urandom_range(0, 3) == 0) ? REQ_ADD : REQ_POP, pick_value());
    wait_idle();

    // A stretch at full rate on both sides.
    sender_idle_en   = 1'b0;
    receiver_idle_en = 1'b0;
    random_burst(20);
    wait_idle();

    sender_idle_en   = 1'b1;
    receiver_idle_en = 1'b1;
    random_burst(12);
    wait_idle();

    $display("Run covered %0d requests and %0d result words: %0d overflows, %0d short-stack",
             n_requests, n_results, n_full, n_short);
    $display("errors, %0d listings up to %0d entries deep.", n_lists, longest_list);
    if (err_count == 0 && expected_words.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
